### rtl/core/sprite_hull_bounds_recovery_defines.svh
// Assertion macros for the sprite hull bounds recovery checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SPRITE_HULL_BOUNDS_RECOVERY_DEFINES_SVH
`define SPRITE_HULL_BOUNDS_RECOVERY_DEFINES_SVH

// Checked on every rising edge outside reset.
`define SHBR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sprite hull bounds recovery: assertion failed");

// Checked on every rising edge, reset included.
`define SHBR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sprite hull bounds recovery: reset assertion failed");

`endif

### rtl/core/shbr_pkg.sv
// Package for the sprite hull bounds recovery block: widths, stream layout,
// pipeline stage types and the pixel conversion helpers. No dependencies.
package shbr_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned DIM_W       = 15;
  localparam int unsigned PIX_W       = 15;
  localparam int unsigned XFORM_W     = 3;
  localparam int unsigned SRC_W       = 18;
  localparam int unsigned PROD_W      = 31;
  localparam int unsigned IN_TDATA_W  = 168;
  localparam int unsigned OUT_TDATA_W = 136;
  localparam int unsigned SWAP_BIT    = 2;

  localparam logic [DIM_W-1:0]   MAX_PAGE_DIM = 15'd16384;
  localparam logic [COORD_W-1:0] ROUND_HALF   = 16'h7FFF;
  localparam logic [COORD_W-1:0] DIV_65535    = 16'hFFFF;

  // output beat layout, used by the checker too
  localparam int unsigned OUT_FRAME_X_MSB = 14;
  localparam int unsigned OUT_SRC_X_LSB   = 62;
  localparam int unsigned OUT_SRC_Y_MSB   = 97;
  localparam int unsigned OUT_TRIMMED     = 98;
  localparam int unsigned OUT_USED_W      = 132;

  typedef struct packed {
    logic [COORD_W-1:0] source_width;
    logic [COORD_W-1:0] source_height;
    logic [COORD_W-1:0] trim_x;
    logic [COORD_W-1:0] trim_y;
    logic               swap;
  } side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] local_x;
    logic signed [COORD_W-1:0] local_y;
    logic [COORD_W-1:0]        u_coord;
    logic [COORD_W-1:0]        v_coord;
    logic [DIM_W-1:0]          page_width;
    logic [DIM_W-1:0]          page_height;
    side_t                     side;
    logic                      last;
  } in_stage_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] local_x;
    logic signed [COORD_W-1:0] local_y;
    logic [COORD_W-1:0]        u_coord;
    logic [COORD_W-1:0]        v_coord;
    logic [PROD_W-1:0]         prod_x;
    logic [PROD_W-1:0]         prod_y;
    side_t                     side;
    logic                      last;
  } prod_stage_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] local_x;
    logic signed [COORD_W-1:0] local_y;
    logic [COORD_W-1:0]        u_coord;
    logic [COORD_W-1:0]        v_coord;
    logic [PIX_W-1:0]          pix_x;
    logic [PIX_W-1:0]          pix_y;
    side_t                     side;
    logic                      last;
  } pix_stage_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_lx;
    logic signed [COORD_W-1:0] max_lx;
    logic signed [COORD_W-1:0] min_ly;
    logic signed [COORD_W-1:0] max_ly;
    logic [PIX_W-1:0]          min_px;
    logic [PIX_W-1:0]          max_px;
    logic [PIX_W-1:0]          min_py;
    logic [PIX_W-1:0]          max_py;
    logic [COORD_W-1:0]        first_u;
    logic [COORD_W-1:0]        first_v;
  } bounds_t;

  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] dim);
    return (dim > MAX_PAGE_DIM) ? MAX_PAGE_DIM : dim;
  endfunction

  // floor((2*prod + 65535) / 131070) == floor((prod + 32767) / 65535)
  // a = q1*65536 + lo = q1*65535 + (lo + q1), remainder stays below 2*65535
  function automatic logic [PIX_W-1:0] pixel_round(input logic [PROD_W-1:0] prod);
    logic [PROD_W-1:0]  a;
    logic [PIX_W-1:0]   q1;
    logic [COORD_W:0]   r1;
    a  = prod + PROD_W'(ROUND_HALF);
    q1 = a[PROD_W-1:COORD_W];
    r1 = {1'b0, a[COORD_W-1:0]} + (COORD_W+1)'(q1);
    return (r1 >= {1'b0, DIV_65535}) ? q1 + PIX_W'(1) : q1;
  endfunction

endpackage

### rtl/core/sprite_hull_bounds_recovery.sv
// Sprite hull bounds recovery: vertex stream in, one frame/trim record out
// per region. Depends on shbr_pkg.
//
// Usage:
//   s_axis carries one hull vertex per beat; tlast marks the region's last
//   vertex. Source size, trim offsets and transform are taken from the last
//   beat only. m_axis carries one record per region, after its last vertex.
//   Throughput: one vertex per cycle, no gaps between regions, unless m_axis stalls.
//   The record shows on m_axis after the last vertex is accepted and has passed
//   the input register, multiply, rounding, bounds update and output registers.
//   The page coordinate multiply is registered before its rounding step,
//   which sets the pipeline depth.
//   Reset empties the pipeline and arms the block for a new region; the
//   running bounds and first u/v clear to zero.
//   When m_axis stalls, the record holds in the output register; one more
//   record waits in the bounds stage, and vertices that do not end a region
//   keep flowing. Once both are full, the next last vertex waits in the
//   rounding register, and s_axis_tready drops when the input and multiply
//   registers behind it are full too.
module sprite_hull_bounds_recovery
  import shbr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // local_x, local_y, u_coord, v_coord, page_width, page_height,
  // source_width, source_height, trim x offset, trim y offset, transform, pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,  // last_vertex
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // frame_x, frame_y, span_width, span_height, source_x, source_y, trimmed,
  // first_u, first_v, status, pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  in_stage_t   a_q;
  prod_stage_t b_q;
  pix_stage_t  c_q;
  bounds_t     d_q;
  side_t       d_side_q;
  logic        a_vld_q, b_vld_q, c_vld_q, d_vld_q, out_vld_q;
  logic        a_vld_d, b_vld_d, c_vld_d, d_vld_d, out_vld_d;
  bounds_t     st_q, st_d;
  logic        awaiting_q, awaiting_d;
  logic [OUT_TDATA_W-1:0] out_q, out_d;

  logic out_free, d_free, c_go, c_free, b_free, a_free;
  logic s_acc, a_go, b_go, d_go, d_load;

  // flow control
  assign out_free = !out_vld_q || m_axis_tready;
  assign d_go     = d_vld_q && out_free;
  assign d_free   = !d_vld_q || out_free;
  assign c_go     = c_vld_q && (!c_q.last || d_free);
  assign c_free   = !c_vld_q || c_go;
  assign b_go     = b_vld_q && c_free;
  assign b_free   = !b_vld_q || c_free;
  assign a_go     = a_vld_q && b_free;
  assign a_free   = !a_vld_q || b_free;
  assign d_load   = c_go && c_q.last;

  assign s_axis_tready = a_free;
  assign s_acc         = s_axis_tvalid && a_free;

  assign a_vld_d   = s_acc || (a_vld_q && !b_free);
  assign b_vld_d   = a_go || (b_vld_q && !c_free);
  assign c_vld_d   = b_go || (c_vld_q && !c_go);
  assign d_vld_d   = d_load || (d_vld_q && !out_free);
  assign out_vld_d = d_go || (out_vld_q && !m_axis_tready);

  // running bounds update
  always_comb begin
    st_d       = st_q;
    awaiting_d = awaiting_q;
    if (c_go) begin
      if (awaiting_q) begin
        st_d.min_lx  = c_q.local_x;
        st_d.max_lx  = c_q.local_x;
        st_d.min_ly  = c_q.local_y;
        st_d.max_ly  = c_q.local_y;
        st_d.min_px  = c_q.pix_x;
        st_d.max_px  = c_q.pix_x;
        st_d.min_py  = c_q.pix_y;
        st_d.max_py  = c_q.pix_y;
        st_d.first_u = c_q.u_coord;
        st_d.first_v = c_q.v_coord;
      end else begin
        if (c_q.local_x < st_q.min_lx) st_d.min_lx = c_q.local_x;
        if (c_q.local_x > st_q.max_lx) st_d.max_lx = c_q.local_x;
        if (c_q.local_y < st_q.min_ly) st_d.min_ly = c_q.local_y;
        if (c_q.local_y > st_q.max_ly) st_d.max_ly = c_q.local_y;
        if (c_q.pix_x < st_q.min_px) st_d.min_px = c_q.pix_x;
        if (c_q.pix_x > st_q.max_px) st_d.max_px = c_q.pix_x;
        if (c_q.pix_y < st_q.min_py) st_d.min_py = c_q.pix_y;
        if (c_q.pix_y > st_q.max_py) st_d.max_py = c_q.pix_y;
      end
      awaiting_d = c_q.last;
    end
  end

  // record assembly from the bounds snapshot
  logic [COORD_W:0]       span_w_full, span_h_full;
  logic [COORD_W-1:0]     span_w, span_h, exp_w, exp_h;
  logic [SRC_W-1:0]       src_x, src_y;
  logic [PIX_W-1:0]       box_w, box_h;
  logic                   trimmed, status;

  always_comb begin
    span_w_full = {d_q.max_lx[COORD_W-1], d_q.max_lx} - {d_q.min_lx[COORD_W-1], d_q.min_lx};
    span_h_full = {d_q.max_ly[COORD_W-1], d_q.max_ly} - {d_q.min_ly[COORD_W-1], d_q.min_ly};
    span_w      = span_w_full[COORD_W-1:0];
    span_h      = span_h_full[COORD_W-1:0];
    src_x       = {2'b00, d_side_q.trim_x} + {{2{d_q.min_lx[COORD_W-1]}}, d_q.min_lx};
    src_y       = {2'b00, d_side_q.source_height} - {2'b00, d_side_q.trim_y}
                  - {{2{d_q.max_ly[COORD_W-1]}}, d_q.max_ly};
    trimmed     = !((src_x == '0) && (src_y == '0) &&
                    (span_w == d_side_q.source_width) && (span_h == d_side_q.source_height));
    exp_w       = d_side_q.swap ? span_h : span_w;
    exp_h       = d_side_q.swap ? span_w : span_h;
    box_w       = d_q.max_px - d_q.min_px;
    box_h       = d_q.max_py - d_q.min_py;
    status      = ({1'b0, box_w} != exp_w) || ({1'b0, box_h} != exp_h);
    out_d       = {(OUT_TDATA_W-OUT_USED_W)'(0), status, d_q.first_v, d_q.first_u, trimmed,
                   src_y, src_x, span_h, span_w, d_q.min_py, d_q.min_px};
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q    <= 1'b0;
      b_vld_q    <= 1'b0;
      c_vld_q    <= 1'b0;
      d_vld_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      st_q       <= '0;
      awaiting_q <= 1'b1;
    end else begin
      a_vld_q    <= a_vld_d;
      b_vld_q    <= b_vld_d;
      c_vld_q    <= c_vld_d;
      d_vld_q    <= d_vld_d;
      out_vld_q  <= out_vld_d;
      st_q       <= st_d;
      awaiting_q <= awaiting_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_q.local_x            <= s_axis_tdata[15:0];
      a_q.local_y            <= s_axis_tdata[31:16];
      a_q.u_coord            <= s_axis_tdata[47:32];
      a_q.v_coord            <= s_axis_tdata[63:48];
      a_q.page_width         <= s_axis_tdata[78:64];
      a_q.page_height        <= s_axis_tdata[93:79];
      a_q.side.source_width  <= s_axis_tdata[109:94];
      a_q.side.source_height <= s_axis_tdata[125:110];
      a_q.side.trim_x        <= s_axis_tdata[141:126];
      a_q.side.trim_y        <= s_axis_tdata[157:142];
      a_q.side.swap          <= s_axis_tdata[158+SWAP_BIT];
      a_q.last               <= s_axis_tlast;
    end
    if (a_go) begin
      b_q.local_x <= a_q.local_x;
      b_q.local_y <= a_q.local_y;
      b_q.u_coord <= a_q.u_coord;
      b_q.v_coord <= a_q.v_coord;
      b_q.prod_x  <= PROD_W'(a_q.u_coord) * PROD_W'(dim_clamp(a_q.page_width));
      b_q.prod_y  <= PROD_W'(a_q.v_coord) * PROD_W'(dim_clamp(a_q.page_height));
      b_q.side    <= a_q.side;
      b_q.last    <= a_q.last;
    end
    if (b_go) begin
      c_q.local_x <= b_q.local_x;
      c_q.local_y <= b_q.local_y;
      c_q.u_coord <= b_q.u_coord;
      c_q.v_coord <= b_q.v_coord;
      c_q.pix_x   <= pixel_round(b_q.prod_x);
      c_q.pix_y   <= pixel_round(b_q.prod_y);
      c_q.side    <= b_q.side;
      c_q.last    <= b_q.last;
    end
    if (d_load) begin
      d_q      <= st_d;
      d_side_q <= c_q.side;
    end
    if (d_go) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

### rtl/core/shbr_checker.sv
// Port-level checker for the sprite hull bounds recovery block, with its bind.
// Depends on shbr_pkg and sprite_hull_bounds_recovery_defines.svh.
`include "sprite_hull_bounds_recovery_defines.svh"

module shbr_checker
  import shbr_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  `SHBR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `SHBR_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `SHBR_ASSERT_RST(a_reset_idle, !rst_ni |-> !m_axis_tvalid)
  `SHBR_ASSERT(a_frame_on_page,
    m_axis_tvalid |-> m_axis_tdata[OUT_FRAME_X_MSB:0] <= MAX_PAGE_DIM)
  `SHBR_ASSERT(a_untrimmed_zero_src,
    m_axis_tvalid && !m_axis_tdata[OUT_TRIMMED] |->
      m_axis_tdata[OUT_SRC_Y_MSB:OUT_SRC_X_LSB] == '0)

endmodule

bind sprite_hull_bounds_recovery shbr_checker u_shbr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/sprite_hull_bounds_recovery_tb.sv
// Self-checking bench for sprite_hull_bounds_recovery: streams hull vertices,
// predicts each region's frame/trim record and checks every record field.
// Depends on shbr_pkg and the block itself.
module sprite_hull_bounds_recovery_tb;
  import shbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RAND_VERTS  = 500;
  localparam int unsigned DRAIN_WAIT  = 8;

  typedef struct {
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic [COORD_W-1:0]        u;
    logic [COORD_W-1:0]        v;
    logic [DIM_W-1:0]          pw;
    logic [DIM_W-1:0]          ph;
    logic [COORD_W-1:0]        sw;
    logic [COORD_W-1:0]        sh;
    logic [COORD_W-1:0]        tx;
    logic [COORD_W-1:0]        ty;
    logic [XFORM_W-1:0]        xf;
    logic                      last;
  } vertex_t;

  typedef struct packed {
    logic [PIX_W-1:0]          frame_x;
    logic [PIX_W-1:0]          frame_y;
    logic [COORD_W-1:0]        span_w;
    logic [COORD_W-1:0]        span_h;
    logic signed [SRC_W-1:0]   src_x;
    logic signed [SRC_W-1:0]   src_y;
    logic                      trimmed;
    logic [COORD_W-1:0]        first_u;
    logic [COORD_W-1:0]        first_v;
    logic                      status;
  } record_t;

  typedef struct {
    vertex_t vtx;
    bit      typed;
    record_t want;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  sprite_hull_bounds_recovery u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // running hull bounds
  logic signed [COORD_W-1:0] hull_lo_x, hull_hi_x, hull_lo_y, hull_hi_y;
  logic [PIX_W-1:0]          pix_lo_x, pix_hi_x, pix_lo_y, pix_hi_y;
  logic [COORD_W-1:0]        first_u_q, first_v_q;
  bit                        await_first;

  record_t  records_due[$];
  dir_row_t dir_tab[$];
  int       errors, n_vtx, n_regions, n_records, n_untrimmed, n_box_bad;
  int       cycles;
  bit       tx_quiet, rx_quiet, hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [PIX_W-1:0] page_pixel(logic [COORD_W-1:0] c,
                                                   logic [DIM_W-1:0] dim);
    longint unsigned d, cc;
    d  = dim;
    cc = c;
    if (d > 16384) d = 16384;
    return PIX_W'((2 * cc * d + 65535) / 131070);
  endfunction

  task automatic track_vertex(input vertex_t t, output bit has_rec, output record_t rec);
    logic [PIX_W-1:0] px, py;
    int span_w, span_h, sx, sy, box_w, box_h, ew, eh;
    px = page_pixel(t.u, t.pw);
    py = page_pixel(t.v, t.ph);
    if (await_first) begin
      hull_lo_x = t.lx; hull_hi_x = t.lx; hull_lo_y = t.ly; hull_hi_y = t.ly;
      pix_lo_x = px; pix_hi_x = px; pix_lo_y = py; pix_hi_y = py;
      first_u_q = t.u; first_v_q = t.v;
      await_first = 1'b0;
    end else begin
      if (t.lx < hull_lo_x) hull_lo_x = t.lx;
      if (t.lx > hull_hi_x) hull_hi_x = t.lx;
      if (t.ly < hull_lo_y) hull_lo_y = t.ly;
      if (t.ly > hull_hi_y) hull_hi_y = t.ly;
      if (px < pix_lo_x) pix_lo_x = px;
      if (px > pix_hi_x) pix_hi_x = px;
      if (py < pix_lo_y) pix_lo_y = py;
      if (py > pix_hi_y) pix_hi_y = py;
    end
    has_rec = t.last;
    rec = '0;
    if (t.last) begin
      span_w = int'(hull_hi_x) - int'(hull_lo_x);
      span_h = int'(hull_hi_y) - int'(hull_lo_y);
      sx     = int'(t.tx) + int'(hull_lo_x);
      sy     = int'(t.sh) - int'(t.ty) - int'(hull_hi_y);
      box_w  = int'(pix_hi_x) - int'(pix_lo_x);
      box_h  = int'(pix_hi_y) - int'(pix_lo_y);
      ew     = t.xf[SWAP_BIT] ? span_h : span_w;
      eh     = t.xf[SWAP_BIT] ? span_w : span_h;
      rec.frame_x = pix_lo_x;
      rec.frame_y = pix_lo_y;
      rec.span_w  = span_w[COORD_W-1:0];
      rec.span_h  = span_h[COORD_W-1:0];
      rec.src_x   = sx[SRC_W-1:0];
      rec.src_y   = sy[SRC_W-1:0];
      rec.trimmed = !(sx == 0 && sy == 0 && span_w == int'(t.sw) && span_h == int'(t.sh));
      rec.first_u = first_u_q;
      rec.first_v = first_v_q;
      rec.status  = (box_w != ew) || (box_h != eh);
      await_first = 1'b1;
    end
  endtask

  function automatic vertex_t mk_vtx(int lx, int ly, int u, int v, int pw, int ph,
                                     int sw, int sh, int tx, int ty, int xf, bit last);
    vertex_t t;
    t.lx = lx[COORD_W-1:0]; t.ly = ly[COORD_W-1:0];
    t.u  = u[COORD_W-1:0];  t.v  = v[COORD_W-1:0];
    t.pw = pw[DIM_W-1:0];   t.ph = ph[DIM_W-1:0];
    t.sw = sw[COORD_W-1:0]; t.sh = sh[COORD_W-1:0];
    t.tx = tx[COORD_W-1:0]; t.ty = ty[COORD_W-1:0];
    t.xf = xf[XFORM_W-1:0]; t.last = last;
    return t;
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return DIM_W'($urandom_range(16385, 32767));
    return DIM_W'($urandom_range(1, 16384));
  endfunction

  function automatic vertex_t rand_vtx();
    vertex_t t;
    t = mk_vtx($urandom, $urandom, $urandom, $urandom, 0, 0,
               $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
    t.pw = rand_dim();
    t.ph = rand_dim();
    return t;
  endfunction

  // u/v that lands exactly on pixel p of a 16384 page
  function automatic int pixel_coord(int p);
    return (p * 65535 + 8192) / 16384;
  endfunction

  // entered and left at a falling edge
  task automatic send_vertex(input vertex_t t, input bit typed, input record_t want);
    int gap;
    bit has_rec;
    record_t rec;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({t.xf, t.ty, t.tx, t.sh, t.sw, t.ph, t.pw,
                                  t.v, t.u, t.ly, t.lx});
    s_axis_tlast  <= t.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_vertex(t, has_rec, rec);
    n_vtx++;
    if (has_rec) begin
      n_regions++;
      records_due.push_back(typed ? want : rec);
    end
    @(negedge clk_i);
  endtask

  task automatic send_region(input bit noise_only);
    int nv, bx, by, ox, oy, lo_x, hi_x, lo_y, hi_y, px, py;
    int dx[8], dy[8];
    bit neat, flat, swp;
    vertex_t t;
    if ($urandom_range(0, 5) == 0) tx_quiet = !tx_quiet;
    nv   = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
    if (noise_only) nv = 1;
    neat = !noise_only && ($urandom_range(0, 9) < 7);
    flat = $urandom_range(0, 1);
    swp  = $urandom_range(0, 1);
    bx   = 0 - int'($urandom_range(200, 3000));
    by   = 0 - int'($urandom_range(200, 3000));
    ox   = $urandom_range(0, 16000);
    oy   = $urandom_range(0, 16000);
    lo_x = 1000; hi_x = -1; lo_y = 1000; hi_y = -1;
    for (int i = 0; i < nv; i++) begin
      dx[i] = $urandom_range(0, 200);
      dy[i] = $urandom_range(0, 200);
      if (dx[i] < lo_x) lo_x = dx[i];
      if (dx[i] > hi_x) hi_x = dx[i];
      if (dy[i] < lo_y) lo_y = dy[i];
      if (dy[i] > hi_y) hi_y = dy[i];
    end
    for (int i = 0; i < nv; i++) begin
      t = rand_vtx();
      t.last = (i == nv - 1);
      if (neat) begin
        // pixel box tracks the local span, swapped on the page when asked
        t.lx = COORD_W'(bx + dx[i]);
        t.ly = COORD_W'(by + dy[i]);
        t.pw = MAX_PAGE_DIM;
        t.ph = MAX_PAGE_DIM;
        px   = ox + (swp ? dy[i] : dx[i]);
        py   = oy + (swp ? dx[i] : dy[i]);
        t.u  = COORD_W'(pixel_coord(px));
        t.v  = COORD_W'(pixel_coord(py));
        t.xf[SWAP_BIT] = swp;
        if (t.last && flat) begin
          t.sw = COORD_W'(hi_x - lo_x);
          t.sh = COORD_W'(hi_y - lo_y);
          t.tx = COORD_W'(-(bx + lo_x));
          t.ty = COORD_W'(-(by + lo_y));
        end
      end
      send_vertex(t, 1'b0, '0);
    end
  endtask

  function automatic void cmp_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // record sink
  initial begin
    int stall;
    record_t got, want;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.frame_x = m_axis_tdata[14:0];
      got.frame_y = m_axis_tdata[29:15];
      got.span_w  = m_axis_tdata[45:30];
      got.span_h  = m_axis_tdata[61:46];
      got.src_x   = m_axis_tdata[79:62];
      got.src_y   = m_axis_tdata[97:80];
      got.trimmed = m_axis_tdata[98];
      got.first_u = m_axis_tdata[114:99];
      got.first_v = m_axis_tdata[130:115];
      got.status  = m_axis_tdata[131];
      if (records_due.size() == 0) begin
        $display("%0t: unexpected record beat, tdata %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = records_due.pop_front();
        n_records++;
        if (!want.trimmed) n_untrimmed++;
        if (want.status) n_box_bad++;
        cmp_field("frame_x", want.frame_x, got.frame_x);
        cmp_field("frame_y", want.frame_y, got.frame_y);
        cmp_field("span_width", want.span_w, got.span_w);
        cmp_field("span_height", want.span_h, got.span_h);
        cmp_field("source_x", $signed(want.src_x), $signed(got.src_x));
        cmp_field("source_y", $signed(want.src_y), $signed(got.src_y));
        cmp_field("trimmed", want.trimmed, got.trimmed);
        cmp_field("first_u", want.first_u, got.first_u);
        cmp_field("first_v", want.first_v, got.first_v);
        cmp_field("status", want.status, got.status);
      end
      if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
      @(negedge clk_i);
    end
  end

  // watchdog
  initial begin
    wait (rst_ni);
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: timeout, %0d records still due", $time, records_due.size());
    $display("sprite_hull_bounds_recovery_tb NOT OK");
    $finish;
  end

  initial begin
    dir_row_t row;
    bit hold_done;
    await_first = 1'b1;
    hull_lo_x = '0; hull_hi_x = '0; hull_lo_y = '0; hull_hi_y = '0;
    pix_lo_x = '0; pix_hi_x = '0; pix_lo_y = '0; pix_hi_y = '0;
    first_u_q = '0; first_v_q = '0;
    hold_done = 1'b0;

    // single vertex, all zero: untrimmed, empty box
    row.vtx = mk_vtx(0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 1'b1);
    row.typed = 1'b1; row.want = '0;
    dir_tab.push_back(row);
    // single vertex at the field extremes, page height saturates
    row.vtx = mk_vtx(-32768, 32767, 65535, 65535, 16384, 32767,
                     65535, 0, 65535, 0, 4, 1'b1);
    row.want = record_t'{15'd16384, 15'd16384, 16'd0, 16'd0, 18'sd32767,
                         -18'sd32767, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0};
    dir_tab.push_back(row);
    row.typed = 1'b0; row.want = '0;
    // full local span, swap set
    row.vtx = mk_vtx(-32768, -32768, 0, 0, 16384, 16384, 0, 0, 0, 0, 0, 1'b0);
    dir_tab.push_back(row);
    row.vtx = mk_vtx(32767, 32767, 65535, 65535, 16384, 16384, 0, 0, 0, 0, 0, 1'b0);
    dir_tab.push_back(row);
    row.vtx = mk_vtx(0, 0, 32768, 32768, 16384, 16384, 65535, 65535, 0, 65535, 4, 1'b1);
    dir_tab.push_back(row);
    // zero page dimensions
    row.vtx = mk_vtx(100, -100, 65535, 65535, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    dir_tab.push_back(row);
    row.vtx = mk_vtx(-100, 100, 1, 1, 0, 0, 200, 200, 100, 0, 0, 1'b1);
    dir_tab.push_back(row);
    // page dimensions above the cap
    row.vtx = mk_vtx(5, 5, 65535, 0, 32767, 16385, 0, 0, 0, 0, 0, 1'b0);
    dir_tab.push_back(row);
    row.vtx = mk_vtx(7, 9, 12345, 54321, 16385, 32767, 3, 4, 1, 2, 3, 1'b1);
    dir_tab.push_back(row);
    // untrimmed region, box equals span
    row.vtx = mk_vtx(0, -5, 0, 0, 16384, 16384, 0, 0, 0, 0, 0, 1'b0);
    dir_tab.push_back(row);
    row.vtx = mk_vtx(10, 5, 40, 40, 16384, 16384, 0, 0, 0, 0, 0, 1'b0);
    dir_tab.push_back(row);
    row.vtx = mk_vtx(5, 0, 20, 20, 16384, 16384, 10, 10, 0, 5, 0, 1'b1);
    dir_tab.push_back(row);
    // box matches span only when swapped; transform low bits ignored
    row.vtx = mk_vtx(0, 0, 0, 0, 16384, 16384, 0, 0, 0, 0, 0, 1'b0);
    dir_tab.push_back(row);
    row.vtx = mk_vtx(20, 10, 40, 80, 16384, 16384, 20, 10, 0, 0, 7, 1'b1);
    dir_tab.push_back(row);
    row.vtx = mk_vtx(0, 0, 0, 0, 16384, 16384, 0, 0, 0, 0, 0, 1'b0);
    dir_tab.push_back(row);
    row.vtx = mk_vtx(20, 10, 40, 80, 16384, 16384, 20, 10, 0, 0, 3, 1'b1);
    dir_tab.push_back(row);
    // one-pixel page, rounding boundary
    row.vtx = mk_vtx(1, 1, 32767, 32768, 1, 1, 0, 0, 0, 0, 0, 1'b0);
    dir_tab.push_back(row);
    row.vtx = mk_vtx(2, 2, 32768, 32767, 1, 1, 1, 1, 0, 0, 0, 1'b1);
    dir_tab.push_back(row);

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) send_vertex(dir_tab[i].vtx, dir_tab[i].typed, dir_tab[i].want);

    // sender pause: let every record drain
    s_axis_tvalid <= 1'b0;
    while (records_due.size() != 0) @(negedge clk_i);

    while (n_vtx < RAND_VERTS + dir_tab.size()) begin
      if (!hold_done && n_vtx >= RAND_VERTS / 2) begin
        // long sink stall with single-vertex regions, back to back while tx_quiet is set
        hold_done = 1'b1;
        hold_req  = 1'b1;
        tx_quiet  = 1'b1;
        repeat (30) send_region(1'b1);
        s_axis_tvalid <= 1'b0;
        while (records_due.size() != 0) @(negedge clk_i);
      end
      send_region(1'b0);
    end
    s_axis_tvalid <= 1'b0;

    while (records_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("run: %0d vertices in %0d regions, %0d records checked", n_vtx, n_regions,
             n_records);
    $display("run: %0d untrimmed records, %0d with box/span mismatch, %0d errors",
             n_untrimmed, n_box_bad, errors);
    if (errors == 0 && records_due.size() == 0) begin
      $display("sprite_hull_bounds_recovery_tb OK");
    end else begin
      $display("sprite_hull_bounds_recovery_tb NOT OK");
    end
    $finish;
  end

endmodule
